@@ rtl/rdse_pkg.sv @@
// Package for the radix digit string encoder: widths, defaults, digit codes,
// the radix clamp and digit-to-ASCII helpers, and the divider status struct.
// No dependencies.
package rdse_pkg;

   localparam int DEF_VALUE_WIDTH = 64;
   localparam int DEF_MAX_DIGITS  = 64;

   localparam int REQ_VALUE_W = 64;
   localparam int RADIX_W     = 5;
   localparam int DIGIT_W     = 4;
   localparam int CHAR_W      = 7;
   localparam int STEP_BITS   = 8;

   localparam logic [RADIX_W-1:0] RADIX_RESET = 5'd10;
   localparam logic [RADIX_W-1:0] RADIX_MIN   = 5'd2;
   localparam logic [RADIX_W-1:0] RADIX_MAX   = 5'd16;

   localparam logic [CHAR_W-1:0]  CHAR_ZERO = 7'd48;
   localparam logic [CHAR_W-1:0]  CHAR_A    = 7'd97;
   localparam logic [DIGIT_W-1:0] DIGIT_TEN = 4'd10;

   typedef struct packed {
      logic done;
      logic zero;
   } div_status_type;

   function automatic logic [RADIX_W-1:0] clamp_radix(input logic [RADIX_W-1:0] v);
      logic [RADIX_W-1:0] r;
      r = v;
      if (v < RADIX_MIN) begin
         r = RADIX_MIN;
      end else if (v > RADIX_MAX) begin
         r = RADIX_MAX;
      end
      return r;
   endfunction

   function automatic logic [CHAR_W-1:0] digit_to_char(input logic [DIGIT_W-1:0] d);
      logic [CHAR_W-1:0] c;
      if (d < DIGIT_TEN) begin
         c = CHAR_ZERO + CHAR_W'(d);
      end else begin
         c = CHAR_A + CHAR_W'(d - DIGIT_TEN);
      end
      return c;
   endfunction

endpackage

@@ rtl/rdse_front.sv @@
// Front end: accepts request beats, drops value bits above VALUE_WIDTH and
// holds the values in a two-entry queue for the back end. Uses rdse_pkg.
module rdse_front import rdse_pkg::*; #(
   parameter int VALUE_WIDTH = DEF_VALUE_WIDTH
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [REQ_VALUE_W-1:0] req_value,
   output logic                   item_valid,
   output logic [VALUE_WIDTH-1:0] item_value,
   input  logic                   item_pop
);

   logic [VALUE_WIDTH-1:0] slot_ff [2];
   logic                   wr_ptr_ff, wr_ptr_in;
   logic                   rd_ptr_ff, rd_ptr_in;
   logic [1:0]             count_ff, count_in;
   logic                   push;
   logic                   pop;

   assign req_stall  = (count_ff == 2'd2);
   assign push       = req_valid && !req_stall;
   assign item_valid = (count_ff != 2'd0);
   assign pop        = item_pop && item_valid;
   assign item_value = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= req_value[VALUE_WIDTH-1:0];
      end
   end

endmodule

@@ rtl/rdse_divider.sv @@
// Iterative divide-by-radix unit: eight restoring quotient bits per cycle,
// one pass over the value per digit. Uses rdse_pkg.
module rdse_divider import rdse_pkg::*; #(
   parameter int VALUE_WIDTH = DEF_VALUE_WIDTH
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic [VALUE_WIDTH-1:0] dividend,
   input  logic [RADIX_W-1:0]     divisor,
   output logic [VALUE_WIDTH-1:0] quotient,
   output logic [DIGIT_W-1:0]     remainder,
   output div_status_type         status
);

   localparam int PASSES = (VALUE_WIDTH + STEP_BITS - 1) / STEP_BITS;
   localparam int PAD_W  = PASSES * STEP_BITS;
   localparam int PCNT_W = (PASSES > 1) ? $clog2(PASSES) : 1;

   logic [PAD_W-1:0]     q_ff, q_in;
   logic [DIGIT_W-1:0]   rem_ff, rem_in;
   logic [RADIX_W-1:0]   div_ff, div_in;
   logic [PCNT_W-1:0]    cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [STEP_BITS-1:0] top_bits;
   logic [STEP_BITS-1:0] q_bits;
   logic [DIGIT_W-1:0]   rem_step;
   logic                 last_pass;

   assign top_bits  = q_ff[PAD_W-1 -: STEP_BITS];
   assign last_pass = (cnt_ff == PCNT_W'(PASSES - 1));

   always_comb begin
      logic [RADIX_W-1:0] part;
      rem_step = rem_ff;
      q_bits   = '0;
      for (int i = 0; i < STEP_BITS; i++) begin
         part = {rem_step, top_bits[STEP_BITS-1-i]};
         if (part >= div_ff) begin
            q_bits[STEP_BITS-1-i] = 1'b1;
            part = part - div_ff;
         end
         rem_step = part[DIGIT_W-1:0];
      end
   end

   always_comb begin
      q_in    = q_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         q_in    = PAD_W'(dividend);
         rem_in  = '0;
         div_in  = divisor;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         q_in   = (q_ff << STEP_BITS) | PAD_W'(q_bits);
         rem_in = rem_step;
         cnt_in = cnt_ff + PCNT_W'(1);
         if (last_pass) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      q_ff   <= q_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
      cnt_ff <= cnt_in;
   end

   assign quotient    = q_ff[VALUE_WIDTH-1:0];
   assign remainder   = rem_ff;
   assign status.done = done_ff;
   assign status.zero = (q_ff == '0);

endmodule

@@ rtl/rdse_back.sv @@
// Back end: runs the divider once per digit into the digit store, then reads
// the store back most significant digit first into the response register.
// Uses rdse_pkg and rdse_divider.
module rdse_back import rdse_pkg::*; #(
   parameter int VALUE_WIDTH = DEF_VALUE_WIDTH,
   parameter int MAX_DIGITS  = DEF_MAX_DIGITS
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   item_valid,
   input  logic [VALUE_WIDTH-1:0] item_value,
   output logic                   item_pop,
   input  logic [RADIX_W-1:0]     radix,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [CHAR_W-1:0]      rsp_digit_char,
   output logic                   rsp_last_digit
);

   localparam int CNT_W  = $clog2(MAX_DIGITS + 1);
   localparam int ADDR_W = $clog2(MAX_DIGITS);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIV,
      ST_READ,
      ST_SEND
   } state_type;

   state_type              state_ff, state_in;
   logic [CNT_W-1:0]       cnt_ff, cnt_in;
   logic [ADDR_W-1:0]      ptr_ff, ptr_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [CHAR_W-1:0]      rsp_char_ff, rsp_char_in;
   logic                   rsp_last_ff, rsp_last_in;
   logic [DIGIT_W-1:0]     digit_store [MAX_DIGITS];
   logic [DIGIT_W-1:0]     rd_data_ff;
   logic                   wr_en;
   logic                   div_start;
   logic [VALUE_WIDTH-1:0] div_dividend;
   logic [VALUE_WIDTH-1:0] div_quotient;
   logic [DIGIT_W-1:0]     div_remainder;
   div_status_type         div_status;
   logic                   rsp_free;

   rdse_divider #(
      .VALUE_WIDTH(VALUE_WIDTH)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (radix),
      .quotient (div_quotient),
      .remainder(div_remainder),
      .status   (div_status)
   );

   assign rsp_free     = !rsp_valid_ff || !rsp_stall;
   assign div_dividend = (state_ff == ST_IDLE) ? item_value : div_quotient;

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      ptr_in       = ptr_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_char_in  = rsp_char_ff;
      rsp_last_in  = rsp_last_ff;
      item_pop     = 1'b0;
      div_start    = 1'b0;
      wr_en        = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (item_valid) begin
               item_pop  = 1'b1;
               div_start = 1'b1;
               cnt_in    = '0;
               state_in  = ST_DIV;
            end
         end
         ST_DIV: begin
            if (div_status.done) begin
               wr_en  = 1'b1;
               cnt_in = cnt_ff + CNT_W'(1);
               if (div_status.zero || cnt_ff == CNT_W'(MAX_DIGITS - 1)) begin
                  ptr_in   = cnt_ff[ADDR_W-1:0];
                  state_in = ST_READ;
               end else begin
                  div_start = 1'b1;
               end
            end
         end
         ST_READ: begin
            state_in = ST_SEND;
         end
         ST_SEND: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_char_in  = digit_to_char(rd_data_ff);
               rsp_last_in  = (ptr_ff == '0);
               if (ptr_ff == '0) begin
                  state_in = ST_IDLE;
               end else begin
                  ptr_in   = ptr_ff - ADDR_W'(1);
                  state_in = ST_READ;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      ptr_ff      <= ptr_in;
      rsp_char_ff <= rsp_char_in;
      rsp_last_ff <= rsp_last_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         digit_store[cnt_ff[ADDR_W-1:0]] <= div_remainder;
      end
      if (state_ff == ST_READ) begin
         rd_data_ff <= digit_store[ptr_ff];
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_digit_char = rsp_char_ff;
   assign rsp_last_digit = rsp_last_ff;

endmodule

@@ rtl/radix_digit_string_encoder.sv @@
// Radix digit string encoder: each request beat carries one unsigned value
// (low VALUE_WIDTH bits used); the block returns one response beat per digit
// in the radix held in the configuration register (writes clamp to 2..16,
// reset 10), most significant digit first, as ASCII '0'-'9' and 'a'-'f',
// with last_digit set on the final beat. Zero gives a single '0'. Values
// needing more than MAX_DIGITS digits emit only the low MAX_DIGITS digits.
// The divider makes eight quotient bits per cycle in ceil(VALUE_WIDTH/8)
// passes per digit, and each beat reads the digit store in ST_READ and is
// then sent from ST_SEND. A two-entry queue takes further request beats
// while an item is in progress. Uses rdse_pkg, rdse_front and rdse_back.
module radix_digit_string_encoder import rdse_pkg::*; #(
   parameter int VALUE_WIDTH = DEF_VALUE_WIDTH,
   parameter int MAX_DIGITS  = DEF_MAX_DIGITS
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [REQ_VALUE_W-1:0] req_value,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [CHAR_W-1:0]      rsp_digit_char,
   output logic                   rsp_last_digit,
   input  logic                   csr_wen,
   input  logic [RADIX_W-1:0]     csr_wdata
);

   logic [RADIX_W-1:0]     radix_ff, radix_in;
   logic                   item_valid;
   logic [VALUE_WIDTH-1:0] item_value;
   logic                   item_pop;

   assign radix_in = csr_wen ? clamp_radix(csr_wdata) : radix_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         radix_ff <= RADIX_RESET;
      end else begin
         radix_ff <= radix_in;
      end
   end

   rdse_front #(
      .VALUE_WIDTH(VALUE_WIDTH)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_value (req_value),
      .item_valid(item_valid),
      .item_value(item_value),
      .item_pop  (item_pop)
   );

   rdse_back #(
      .VALUE_WIDTH(VALUE_WIDTH),
      .MAX_DIGITS (MAX_DIGITS)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .item_valid    (item_valid),
      .item_value    (item_value),
      .item_pop      (item_pop),
      .radix         (radix_ff),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_digit_char(rsp_digit_char),
      .rsp_last_digit(rsp_last_digit)
   );

`ifndef SYNTH
   a_radix_range: assert property (@(posedge clock) disable iff (reset)
      radix_ff >= RADIX_MIN && radix_ff <= RADIX_MAX)
      else $error("radix register outside 2..16");

   a_pop_has_item: assert property (@(posedge clock) disable iff (reset)
      item_pop |-> item_valid)
      else $error("back end popped an empty queue");

   a_char_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_digit_char >= CHAR_ZERO && rsp_digit_char <= 7'd57) ||
                     (rsp_digit_char >= CHAR_A && rsp_digit_char <= 7'd102)))
      else $error("response beat carries a non-digit character");
`endif

endmodule
